### rtl/hcf_pkg.sv
// ----------------------------------------------------------------------------
// hcf_pkg: shared types and constants for the hex text to CAN frame parser
// Character codes, parse phases, field widths and the frame result record.
// ----------------------------------------------------------------------------
`default_nettype none

package hcf_pkg;

  localparam int unsigned MAX_BYTES  = 8;
  localparam int unsigned DATA_SLOTS = 8;
  localparam int unsigned BYTE_IDX_W = 3;
  localparam int unsigned ID_W       = 29;
  localparam int unsigned NIB_CNT_W  = 5;
  localparam int unsigned BYTE_CNT_W = 4;

  localparam logic [7:0] CHAR_START = 8'h53;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] HEX_LETTER_OFS = 8'd7;

  localparam logic [ID_W-1:0]      STD_ID_MAX = ID_W'(32'h7FF);
  localparam logic [NIB_CNT_W-1:0] NIB_LIMIT  = NIB_CNT_W'(2 * MAX_BYTES);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ID   = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  typedef struct packed {
    logic [ID_W-1:0]                 frame_id;
    logic                            extended_id;
    logic [BYTE_CNT_W-1:0]           byte_count;
    logic [DATA_SLOTS-1:0][7:0]      data;
  } frame_t;

  function automatic logic [3:0] hex_digit(input logic [7:0] ch);
    logic [7:0] adj;
    adj = (ch > CHAR_NINE) ? (ch - HEX_LETTER_OFS) : ch;
    return adj[3:0];
  endfunction

endpackage

`default_nettype wire

### rtl/hcf_parser.sv
// ----------------------------------------------------------------------------
// hcf_parser: parse state and frame assembly
// Holds the phase, identifier, nibble count and payload bytes, updates them
// for the staged character and forms the frame when a terminator arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module hcf_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          char_i,
  output logic                emit_o,
  output hcf_pkg::frame_t     frame_o
);
  import hcf_pkg::*;

  phase_e                     phase_q, phase_d;
  logic [ID_W-1:0]            id_q, id_d;
  logic [NIB_CNT_W-1:0]       nib_q, nib_d;
  logic [DATA_SLOTS-1:0][7:0] pay_q, pay_d;
  logic [3:0]                 digit;
  logic [BYTE_IDX_W-1:0]      wr_idx;
  logic [BYTE_CNT_W-1:0]      count;
  logic                       emit;

  assign digit  = hex_digit(char_i);
  assign wr_idx = nib_q[BYTE_IDX_W:1];
  assign count  = nib_q[NIB_CNT_W-1:1];

  always_comb begin
    phase_d = phase_q;
    id_d    = id_q;
    nib_d   = nib_q;
    pay_d   = pay_q;
    emit    = 1'b0;
    case (phase_q)
      PH_ID: begin
        if (char_i == CHAR_HASH) begin
          phase_d = PH_DATA;
          nib_d   = '0;
        end else begin
          id_d = {id_q[ID_W-5:0], digit};
        end
      end
      PH_DATA: begin
        if (char_i >= CHAR_ZERO) begin
          if (nib_q < NIB_LIMIT) begin
            pay_d[wr_idx] = {pay_q[wr_idx][3:0], digit};
            nib_d         = nib_q + NIB_CNT_W'(1);
          end
        end else begin
          emit    = 1'b1;
          phase_d = PH_IDLE;
        end
      end
      default: begin
        if (char_i == CHAR_START) begin
          phase_d = PH_ID;
          id_d    = '0;
        end else begin
          phase_d = PH_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    frame_o.frame_id    = id_q;
    frame_o.extended_id = (id_q > STD_ID_MAX);
    frame_o.byte_count  = count;
    for (int k = 0; k < DATA_SLOTS; k++) begin
      frame_o.data[k] = (BYTE_CNT_W'(k) < count) ? pay_q[k] : 8'h00;
    end
  end

  assign emit_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      id_q    <= '0;
      nib_q   <= '0;
      pay_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      id_q    <= id_d;
      nib_q   <= nib_d;
      pay_q   <= pay_d;
    end
  end

endmodule

`default_nettype wire

### rtl/hcf_out_reg.sv
// ----------------------------------------------------------------------------
// hcf_out_reg: frame result register
// Holds one finished frame until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hcf_out_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  hcf_pkg::frame_t frame_i,
  input  logic            ready_i,
  output logic            valid_o,
  output hcf_pkg::frame_t frame_o
);
  import hcf_pkg::*;

  logic   valid_q, valid_d;
  frame_t frame_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frame_q <= frame_i;
    end
  end

  assign valid_o = valid_q;
  assign frame_o = frame_q;

endmodule

`default_nettype wire

### rtl/hex_text_to_can_frame.sv
// ----------------------------------------------------------------------------
// hex_text_to_can_frame: ASCII hex text line to CAN data frame parser
// Takes one character per transfer on the input channel and returns one
// frame on the output channel for every line S<id>#<data> that is ended
// by a character below '0'.
//
// A character taken on the input channel is first held in an input
// register. When it advances, the parser updates its state from it and,
// for a terminator, loads the frame into the result register, from which
// the frame is offered on the output channel.
// The block takes one character in every cycle. It stalls the input only
// when a terminator waits in the input register while the result register
// still holds a frame that the receiver has not yet taken; characters that
// produce no frame keep flowing while the receiver stalls.
// Reset clears the parse state to idle and empties both registers.
// Data bytes at or beyond the byte count read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_text_to_can_frame (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [7:0]                           character_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [hcf_pkg::ID_W-1:0]             frame_id_o,
  output logic                                 extended_id_o,
  output logic [hcf_pkg::BYTE_CNT_W-1:0]       byte_count_o,
  output logic [7:0]                           data_byte0_o,
  output logic [7:0]                           data_byte1_o,
  output logic [7:0]                           data_byte2_o,
  output logic [7:0]                           data_byte3_o,
  output logic [7:0]                           data_byte4_o,
  output logic [7:0]                           data_byte5_o,
  output logic [7:0]                           data_byte6_o,
  output logic [7:0]                           data_byte7_o
);
  import hcf_pkg::*;

  logic       stg_valid_q, stg_valid_d;
  logic [7:0] stg_char_q;
  logic       stg_emit;
  logic       out_free;
  logic       advance;
  logic       in_fire;
  frame_t     stg_frame;
  frame_t     out_frame;

  assign out_free   = !out_valid_o || out_ready_i;
  assign advance    = stg_valid_q && (!stg_emit || out_free);
  assign in_ready_o = !stg_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (in_fire) begin
      stg_valid_d = 1'b1;
    end else if (advance) begin
      stg_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stg_char_q <= character_i;
    end
  end

  hcf_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .char_i  (stg_char_q),
    .emit_o  (stg_emit),
    .frame_o (stg_frame)
  );

  hcf_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && stg_emit),
    .frame_i (stg_frame),
    .ready_i (out_ready_i),
    .valid_o (out_valid_o),
    .frame_o (out_frame)
  );

  assign frame_id_o    = out_frame.frame_id;
  assign extended_id_o = out_frame.extended_id;
  assign byte_count_o  = out_frame.byte_count;
  assign data_byte0_o  = out_frame.data[0];
  assign data_byte1_o  = out_frame.data[1];
  assign data_byte2_o  = out_frame.data[2];
  assign data_byte3_o  = out_frame.data[3];
  assign data_byte4_o  = out_frame.data[4];
  assign data_byte5_o  = out_frame.data[5];
  assign data_byte6_o  = out_frame.data[6];
  assign data_byte7_o  = out_frame.data[7];

  // The input stalls only behind a terminator blocked by an untaken frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (stg_valid_q && stg_emit && out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_count_o <= BYTE_CNT_W'(MAX_BYTES)))
    else $error("byte count above the payload limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (extended_id_o == (frame_id_o > STD_ID_MAX)))
    else $error("extended flag does not match the identifier");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (byte_count_o == '0)) |-> (data_byte0_o == 8'h00))
    else $error("data byte beyond count is not zero");

endmodule

`default_nettype wire
